@@ rtl/core/fixed_point_convolution_tap_mac_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef FIXED_POINT_CONVOLUTION_TAP_MAC_DEFINES_SVH
`define FIXED_POINT_CONVOLUTION_TAP_MAC_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FPCTM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FPCTM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/core/fpctm_pkg.sv @@
package fpctm_pkg;

  localparam int DATA_W   = 8;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = 24;
  localparam int ACC_W    = 32;
  localparam int TAPCNT_W = 9;
  localparam int SHIFT_W  = 5;
  localparam int BIAS_W   = 16;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic [1:0] REG_TAP_COUNT = 2'd0;
  localparam logic [1:0] REG_SHIFT     = 2'd1;
  localparam logic [1:0] REG_BIAS      = 2'd2;

  typedef struct packed {
    logic [TAPCNT_W-1:0]      tap_count;
    logic [SHIFT_W-1:0]       shift;
    logic signed [BIAS_W-1:0] bias;
  } cfg_t;

endpackage

@@ rtl/core/fpctm_coef_mem.sv @@
module fpctm_coef_mem
  import fpctm_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [AW-1:0]            addr,
  input  logic signed [COEF_W-1:0] wdata,
  output logic signed [COEF_W-1:0] rdata
);

  logic signed [COEF_W-1:0] mem [DEPTH];
  logic signed [COEF_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/fpctm_regs.sv @@
module fpctm_regs
  import fpctm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [TAPCNT_W-1:0]      tap_count_r;
  logic [SHIFT_W-1:0]       shift_r;
  logic signed [BIAS_W-1:0] bias_r;
  logic                     wr_en;
  logic [1:0]               reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAPCNT_W'(1);
      shift_r     <= SHIFT_W'(1);
      bias_r      <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TAP_COUNT: tap_count_r <= pwdata[TAPCNT_W-1:0];
        REG_SHIFT:     shift_r     <= pwdata[SHIFT_W-1:0];
        REG_BIAS:      bias_r      <= pwdata[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TAP_COUNT: prdata = PDATA_W'(tap_count_r);
      REG_SHIFT:     prdata = PDATA_W'(shift_r);
      REG_BIAS:      prdata = {{(PDATA_W-BIAS_W){bias_r[BIAS_W-1]}}, bias_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.tap_count = tap_count_r;
  assign cfg.shift     = shift_r;
  assign cfg.bias      = bias_r;

endmodule

@@ rtl/core/fpctm_post.sv @@
module fpctm_post
  import fpctm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    sum_valid,
  input  logic [ACC_W-1:0]        sum,
  output logic                    sum_ready,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [DATA_W-1:0]       out_pixel_out
);

  // three elastic stages: sum hold, round+shift, bias+clamp
  logic                    s3_v_r, s4_v_r, o_v_r;
  logic [ACC_W-1:0]        fin_r;
  logic signed [ACC_W-1:0] shf_r;
  logic [DATA_W-1:0]       pix_r;

  logic                    out_free, s4_mv, s4_free, s3_mv, s3_free;
  logic [ACC_W-1:0]        rnd;
  logic signed [ACC_W-1:0] rounded;
  logic signed [ACC_W-1:0] shifted;
  logic signed [ACC_W-1:0] biased;
  logic [DATA_W-1:0]       clamped;

  assign out_free  = !o_v_r || !out_stall;
  assign s4_mv     = s4_v_r && out_free;
  assign s4_free   = !s4_v_r || s4_mv;
  assign s3_mv     = s3_v_r && s4_free;
  assign s3_free   = !s3_v_r || s3_mv;
  assign sum_ready = s3_free;

  always_comb begin
    if (cfg.shift == '0) begin
      rnd = '0;
    end else begin
      rnd = ACC_W'(1) << (cfg.shift - SHIFT_W'(1));
    end
    rounded = $signed(fin_r + rnd);
    shifted = rounded >>> cfg.shift;
  end

  always_comb begin
    biased = shf_r + {{(ACC_W-BIAS_W){cfg.bias[BIAS_W-1]}}, cfg.bias};
    if (biased[ACC_W-1]) begin
      clamped = '0;
    end else if (|biased[ACC_W-2:DATA_W]) begin
      clamped = '1;
    end else begin
      clamped = biased[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s3_free) begin
        s3_v_r <= sum_valid;
      end
      if (s4_free) begin
        s4_v_r <= s3_v_r;
      end
      if (out_free) begin
        o_v_r <= s4_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free && sum_valid) begin
      fin_r <= sum;
    end
    if (s3_mv) begin
      shf_r <= shifted;
    end
    if (s4_mv) begin
      pix_r <= clamped;
    end
  end

  assign out_valid     = o_v_r;
  assign out_pixel_out = pix_r;

endmodule

@@ rtl/core/fixed_point_convolution_tap_mac.sv @@
// Convolution tap MAC. Load transfers (kind 0) write one coefficient into a
// single-port coefficient RAM of MAX_TAPS entries; pixel transfers (kind 1)
// bring the sample of the next tap and are multiplied by that tap's
// coefficient and summed in a 32-bit wrapping accumulator. On the last tap
// of a pixel the sum is rounded, shifted right by shift, offset by bias,
// clamped to 0..255 and presented on the out_ channel. One transfer is taken
// per clock while in_stall is low; each item makes at most one access to the
// coefficient RAM, so loads and pixels may be mixed freely. A result passes
// the sample, product, sum, shift and clamp registers. Output back-pressure
// stalls the input only once the result stages behind the output register
// are full. Coefficients must be loaded before the taps that use them.
module fixed_point_convolution_tap_mac
  import fpctm_pkg::*;
#(
  parameter int MAX_TAPS = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_kind,
  input  logic [7:0]               in_tap_index,
  input  logic signed [COEF_W-1:0] in_coefficient,
  input  logic [DATA_W-1:0]        in_pixel,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DATA_W-1:0]        out_pixel_out,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = $clog2(MAX_TAPS + 1);

  cfg_t cfg;

  logic                     accept, pix_acc, load_ok, mem_we, mem_re;
  logic [AW-1:0]            mem_addr;
  logic signed [COEF_W-1:0] coef;
  logic [CW-1:0]            eff_taps, cnt_r, cnt_inc, cnt_nxt;
  logic                     last;

  logic                     s1_v_r, s1_last_r;
  logic [DATA_W-1:0]        s1_pix_r;
  logic                     s2_v_r, s2_last_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W:0]   prod_full;
  logic [ACC_W-1:0]         acc_r, acc_sum;

  logic                     post_rdy, s1_mv, s2_mv, s2_free, sum_valid;

  fpctm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    if (cfg.tap_count == '0) begin
      eff_taps = CW'(1);
    end else if (32'(cfg.tap_count) > 32'(MAX_TAPS)) begin
      eff_taps = CW'(MAX_TAPS);
    end else begin
      eff_taps = CW'(cfg.tap_count);
    end
  end

  assign cnt_inc = cnt_r + CW'(1);
  // lowered tap count mid-pixel: counter already past it ends the pixel
  assign last    = (cnt_inc >= eff_taps);
  assign cnt_nxt = last ? '0 : cnt_inc;

  // elastic handshake back from the result stages
  assign s2_mv    = s2_v_r && (!s2_last_r || post_rdy);
  assign s2_free  = !s2_v_r || s2_mv;
  assign s1_mv    = s1_v_r && s2_free;
  assign in_stall = s1_v_r && !s1_mv;

  assign accept  = in_valid && !in_stall;
  assign pix_acc = accept && (in_kind == KIND_PIXEL);
  assign load_ok = (32'(in_tap_index) < 32'(MAX_TAPS));
  assign mem_we  = accept && (in_kind == KIND_LOAD) && load_ok;
  assign mem_re  = pix_acc;
  assign mem_addr = (in_kind == KIND_LOAD) ? AW'(in_tap_index) : cnt_r[AW-1:0];

  fpctm_coef_mem #(
    .DEPTH (MAX_TAPS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (in_coefficient),
    .rdata (coef)
  );

  assign prod_full = coef * $signed({1'b0, s1_pix_r});
  assign acc_sum   = acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign sum_valid = s2_mv && s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      acc_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (pix_acc) begin
        cnt_r <= cnt_nxt;
      end
      s1_v_r <= pix_acc || (s1_v_r && !s2_free);
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (s2_mv) begin
        acc_r <= s2_last_r ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_pix_r  <= in_pixel;
      s1_last_r <= last;
    end
    if (s1_mv) begin
      prod_r    <= prod_full[PROD_W-1:0];
      s2_last_r <= s1_last_r;
    end
  end

  fpctm_post u_post (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .sum_valid     (sum_valid),
    .sum           (acc_sum),
    .sum_ready     (post_rdy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out)
  );

endmodule

@@ rtl/core/fpctm_checker.sv @@
`include "fixed_point_convolution_tap_mac_defines.svh"

module fpctm_checker
  import fpctm_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [DATA_W-1:0]        out_pixel_out,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic [PADDR_W-1:0]       paddr,
  input logic [PDATA_W-1:0]       pwdata,
  input logic [PDATA_W-1:0]       prdata,
  input logic                     pready
);

  logic [PADDR_W-1:0] shift_addr, bias_addr;
  logic               cfg_wr;

  assign shift_addr = {REG_SHIFT, 2'b00};
  assign bias_addr  = {REG_BIAS, 2'b00};
  assign cfg_wr     = psel && penable && pwrite && pready;

  // held result must not change under back-pressure
  `FPCTM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_pixel_out))
  // input back-pressure only arises from a full, stalled output
  `FPCTM_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
  // written shift reads back
  `FPCTM_ASSERT_NEXT(a_shift_rb, cfg_wr && paddr == shift_addr, paddr != shift_addr || prdata[SHIFT_W-1:0] == $past(pwdata[SHIFT_W-1:0]))
  // written bias reads back
  `FPCTM_ASSERT_NEXT(a_bias_rb, cfg_wr && paddr == bias_addr, paddr != bias_addr || prdata[BIAS_W-1:0] == $past(pwdata[BIAS_W-1:0]))

endmodule

bind fixed_point_convolution_tap_mac fpctm_checker u_fpctm_checker (.*);
